[design/rast_pkg.sv]
// Shared constants and types for the range-assign / range-sum tree.
`default_nettype none
package rast_pkg;

	localparam int LEAVES     = 1024;
	localparam int LOG_LEAVES = $clog2(LEAVES);
	localparam int NODES      = 2 * LEAVES;
	localparam int NODE_W     = LOG_LEAVES + 1;
	localparam int LVL_W      = $clog2(LOG_LEAVES + 1);
	localparam int LVLS       = LOG_LEAVES + 1;
	localparam int LOW_W      = 10;
	localparam int HIGH_W     = 11;
	localparam int VAL_W      = 8;
	localparam int SUM_W      = 18;
	localparam int DELTA_W    = SUM_W + 1;

	localparam logic REQ_ASSIGN = 1'b0;
	localparam logic REQ_SUM    = 1'b1;

	typedef struct packed {
		logic             pend;
		logic [VAL_W-1:0] val;
	} tag_t;

	typedef struct packed {
		logic              kind;
		logic [LOW_W-1:0]  low;
		logic [HIGH_W-1:0] high;
		logic [VAL_W-1:0]  val;
	} req_t;

	typedef struct packed {
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
		logic              sum_we;
		logic [NODE_W-1:0] sum_waddr;
		logic [SUM_W-1:0]  sum_wdata;
		logic              tag_we;
		logic [NODE_W-1:0] tag_waddr;
		tag_t              tag_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		tag_t             tag;
	} mem_rsp_t;

endpackage
`default_nettype wire

[design/rast_node_mem.sv]
// Node sum and lazy tag memories with the clearing pass after reset.
`default_nettype none
module rast_node_mem
	import rast_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t mreq,
	output mem_rsp_t      mrsp,
	output logic          clr_busy
);

	logic [SUM_W-1:0] sum_mem [NODES];
	tag_t             tag_mem [NODES];
	logic [NODE_W:0]  clr_q;

	logic              sum_we, tag_we;
	logic [NODE_W-1:0] sum_wa, tag_wa;
	logic [SUM_W-1:0]  sum_wd;
	tag_t              tag_wd;

	assign clr_busy = ~clr_q[NODE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// clearing pass overrides the walker
	always_comb begin
		if (clr_busy) begin
			sum_we = 1'b1;
			tag_we = 1'b1;
			sum_wa = clr_q[NODE_W-1:0];
			tag_wa = clr_q[NODE_W-1:0];
			sum_wd = '0;
			tag_wd = '0;
		end else begin
			sum_we = mreq.sum_we;
			tag_we = mreq.tag_we;
			sum_wa = mreq.sum_waddr;
			tag_wa = mreq.tag_waddr;
			sum_wd = mreq.sum_wdata;
			tag_wd = mreq.tag_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			mrsp.sum <= sum_mem[mreq.rd_addr];
			mrsp.tag <= tag_mem[mreq.rd_addr];
		end
	end

endmodule
`default_nettype wire

[design/rast_walk.sv]
// Tree walk sequencer: depth-first descent, lazy tag handling and write-back.
`default_nettype none
module rast_walk
	import rast_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire req_t     req,
	output logic          idle,
	output mem_req_t      mreq,
	input  wire mem_rsp_t mrsp,
	output logic          res_valid,
	output logic [SUM_W-1:0] res_sum,
	input  wire logic     res_ready
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_EV   = 8'b0000_0100,
		ST_UP   = 8'b0000_1000,
		ST_RET  = 8'b0001_0000,
		ST_FIN  = 8'b0010_0000,
		ST_WB   = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} st_t;

	st_t st_q, st_d;

	logic                       kind_q;
	logic [HIGH_W-1:0]          a_q, b_q;
	logic [VAL_W-1:0]           val_q;
	logic [NODE_W-1:0]          x_q;
	logic [LVL_W-1:0]           lvl_q;
	tag_t                       inh_q;
	logic signed [DELTA_W-1:0]  cdelta_q;
	logic [SUM_W-1:0]           acc_q;
	logic                       from_left_q;
	logic [SUM_W-1:0]           fr_s_q [LVLS];
	logic signed [DELTA_W-1:0]  fr_d_q [LVLS];
	tag_t                       fr_e_q [LVLS];

	logic [LVL_W-1:0]  sh, lvl_up;
	logic [NODE_W-1:0] offs;
	logic [HIGH_W-1:0] lo, span, hi, mid, a_in, b_in;
	logic              covered, nonempty;
	tag_t              e;
	logic [SUM_W-1:0]  s, val_span, wb_sum;
	logic [NODE_W-1:0] left_c, right_c;

	assign sh       = LVL_W'(LOG_LEAVES) - lvl_q;
	assign lvl_up   = lvl_q - 1'b1;
	assign offs     = x_q ^ (NODE_W'(1) << lvl_q);
	assign lo       = HIGH_W'(offs) << sh;
	assign span     = HIGH_W'(1) << sh;
	assign hi       = lo + span;
	assign mid      = lo + (span >> 1);
	assign covered  = (a_q <= lo) && (hi <= b_q);
	assign e        = inh_q.pend ? inh_q : mrsp.tag;
	assign s        = e.pend ? (SUM_W'(e.val) << sh) : mrsp.sum;
	assign val_span = SUM_W'(val_q) << sh;
	assign left_c   = {x_q[NODE_W-2:0], 1'b0};
	assign right_c  = {x_q[NODE_W-2:0], 1'b1};
	assign wb_sum   = SUM_W'($signed({1'b0, fr_s_q[lvl_q]}) + fr_d_q[lvl_q]);

	// clamp the range to the leaf count
	assign a_in = ({1'b0, req.low} > HIGH_W'(LEAVES)) ? HIGH_W'(LEAVES) : {1'b0, req.low};
	assign b_in = (req.high > HIGH_W'(LEAVES)) ? HIGH_W'(LEAVES) : req.high;
	assign nonempty = a_in < b_in;

	assign idle      = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_DONE);
	assign res_sum   = acc_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					if (nonempty) begin
						st_d = ST_RD;
					end else if (req.kind == REQ_SUM) begin
						st_d = ST_DONE;
					end
				end
			end
			ST_RD:  st_d = ST_EV;
			ST_EV:  st_d = covered ? ST_UP : ST_RD;
			ST_UP: begin
				if (lvl_q == '0) begin
					st_d = (kind_q == REQ_SUM) ? ST_DONE : ST_IDLE;
				end else begin
					st_d = ST_RET;
				end
			end
			ST_RET: begin
				if (from_left_q && (mid < b_q)) begin
					st_d = ST_RD;
				end else begin
					st_d = (kind_q == REQ_ASSIGN) ? ST_FIN : ST_UP;
				end
			end
			ST_FIN:  st_d = ST_WB;
			ST_WB:   st_d = ST_UP;
			ST_DONE: st_d = res_ready ? ST_IDLE : ST_DONE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mreq = '0;
		case (st_q)
			ST_RD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = x_q;
			end
			ST_EV: begin
				if (covered && kind_q == REQ_ASSIGN) begin
					mreq.tag_we    = 1'b1;
					mreq.tag_waddr = x_q;
					mreq.tag_wdata = '{pend: 1'b1, val: val_q};
				end
			end
			ST_FIN: begin
				// hand the inherited tag to the child left out of the walk
				if (fr_e_q[lvl_q].pend) begin
					if (from_left_q) begin
						mreq.tag_we    = 1'b1;
						mreq.tag_waddr = right_c;
					end else if (a_q >= mid) begin
						mreq.tag_we    = 1'b1;
						mreq.tag_waddr = left_c;
					end
				end
				mreq.tag_wdata = fr_e_q[lvl_q];
			end
			ST_WB: begin
				mreq.sum_we    = 1'b1;
				mreq.sum_waddr = x_q;
				mreq.sum_wdata = wb_sum;
				mreq.tag_we    = 1'b1;
				mreq.tag_waddr = x_q;
				mreq.tag_wdata = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				kind_q <= req.kind;
				a_q    <= a_in;
				b_q    <= b_in;
				val_q  <= req.val;
				x_q    <= NODE_W'(1);
				lvl_q  <= '0;
				inh_q  <= '0;
				acc_q  <= '0;
			end
			ST_EV: begin
				if (covered) begin
					if (kind_q == REQ_SUM) begin
						acc_q    <= acc_q + s;
						cdelta_q <= '0;
					end else begin
						cdelta_q <= $signed({1'b0, val_span}) - $signed({1'b0, s});
					end
				end else begin
					fr_s_q[lvl_q] <= s;
					fr_d_q[lvl_q] <= '0;
					fr_e_q[lvl_q] <= e;
					inh_q         <= e;
					x_q           <= (a_q < mid) ? left_c : right_c;
					lvl_q         <= lvl_q + 1'b1;
				end
			end
			ST_UP: begin
				if (lvl_q != '0) begin
					fr_d_q[lvl_up] <= fr_d_q[lvl_up] + cdelta_q;
					x_q            <= x_q >> 1;
					lvl_q          <= lvl_up;
					from_left_q    <= ~x_q[0];
				end
			end
			ST_RET: begin
				if (from_left_q && (mid < b_q)) begin
					x_q   <= right_c;
					lvl_q <= lvl_q + 1'b1;
					inh_q <= fr_e_q[lvl_q];
				end else begin
					cdelta_q <= '0;
				end
			end
			ST_WB: begin
				cdelta_q <= fr_d_q[lvl_q];
			end
			default: begin
			end
		endcase
	end

	a_node_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD |-> (x_q >> lvl_q) == NODE_W'(1))
		else $error("node index does not match tree level");

	a_leaf_never_split: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EV && !covered) |-> lvl_q != LVL_W'(LOG_LEAVES))
		else $error("leaf treated as partially covered");

	a_sum_is_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE && kind_q == REQ_SUM) |-> (!mreq.sum_we && !mreq.tag_we))
		else $error("sum transaction wrote node memory");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> (!mreq.sum_we && !mreq.tag_we && !mreq.rd_en))
		else $error("memory access while idle");

endmodule
`default_nettype wire

[design/range_assign_range_sum_tree_unit.sv]
// Top level of the range-assign / range-sum lazy segment tree.
`default_nettype none
// Holds LEAVES (1024) 8-bit values as a lazy segment tree in two node
// memories (sums and assignment tags, 2048 entries each, registered read).
// A transaction either assigns assign_value over [range_low, range_high) and
// returns nothing, or returns range_sum over that range; bounds are clamped to
// the leaf count and an empty range changes nothing and sums to zero. After
// reset a clearing pass zeroes all 2048 entries of both memories; in_stall
// stays high meanwhile. One transaction is walked at a time: each visited
// node is read, then evaluated, going down, and on the way back the walker
// climbs and decides; each partially covered node adds a sibling tag step
// and a write-back for an assignment. A finished sum waits in the output
// register and does not block acceptance of the next transaction; a further
// sum is held by the walker, with in_stall high, while out_stall holds
// that register.
module range_assign_range_sum_tree_unit
	import rast_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [LOW_W-1:0]  range_low,
	input  wire logic [HIGH_W-1:0] range_high,
	input  wire logic [VAL_W-1:0]  assign_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [SUM_W-1:0]       range_sum
);

	mem_req_t         mreq;
	mem_rsp_t         mrsp;
	req_t             req;
	logic             clr_busy, walk_idle, start;
	logic             res_valid, res_ready;
	logic [SUM_W-1:0] res_sum;
	logic             out_valid_q;
	logic [SUM_W-1:0] range_sum_q;

	// take a transaction only when the walker is free and memory is cleared
	assign in_stall = ~walk_idle | clr_busy;
	assign start    = in_valid & ~in_stall;
	assign req      = '{kind: req_type, low: range_low, high: range_high, val: assign_value};

	rast_node_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.mreq     (mreq),
		.mrsp     (mrsp),
		.clr_busy (clr_busy)
	);

	rast_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (walk_idle),
		.mreq      (mreq),
		.mrsp      (mrsp),
		.res_valid (res_valid),
		.res_sum   (res_sum),
		.res_ready (res_ready)
	);

	// output register: refill as soon as the waiting result is taken
	assign res_ready = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			range_sum_q <= res_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

endmodule
`default_nettype wire
